// ===== design/imu_moving_average_scaler_defines.svh =====
// ----------------------------------------------------------------------------
// IMU moving average scaler assertion macros
// Shared macros for the concurrent checks on the scaler ports.
// ----------------------------------------------------------------------------
`ifndef IMU_MOVING_AVERAGE_SCALER_DEFINES_SVH
`define IMU_MOVING_AVERAGE_SCALER_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define IMAS_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// Condition that must never be seen outside reset.
`define IMAS_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error(msg);

`endif

// ===== design/imas_pkg.sv =====
// ----------------------------------------------------------------------------
// IMU moving average scaler package
// Shared types, widths and constants of the scaler.
// ----------------------------------------------------------------------------
package imas_pkg;

	localparam int WINDOW_DEF = 20;
	localparam int RAW_W      = 16;
	localparam int N_AXES     = 6;
	localparam int GYRO_W     = 20;
	localparam int GV_W       = 21;
	localparam int OFS_W      = 17;
	localparam int DB_W       = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int GYRO_SCALE = 1000;
	localparam int GYRO_SHIFT = 7;

	localparam logic signed [GV_W-1:0] GYRO_MAX = 21'sd327680;
	localparam logic signed [GV_W-1:0] GYRO_MIN = -21'sd327680;
	localparam logic [DB_W-1:0] YAW_DEADBAND_RST = 16'd1024;

	localparam logic [CFG_IDX_W-1:0] CFG_GYRO_OFFSET_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GYRO_OFFSET_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GYRO_OFFSET_Z = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_YAW_DEADBAND  = 3'd3;

	// Axes 0 to 2 are accel x, y, z; axes 3 to 5 are gyro x, y, z.
	typedef logic [N_AXES-1:0][RAW_W-1:0] sample_t;
	typedef logic [2:0][RAW_W-1:0] tri_t;

	typedef struct packed {
		logic s2;
		logic s3;
	} lane_en_t;

endpackage

// ===== design/imas_cell.sv =====
// ----------------------------------------------------------------------------
// IMU moving average window cell
// Holds one inertial sample and hands it to the next cell on every item.
// ----------------------------------------------------------------------------
module imas_cell (
	input  logic              clk,
	input  logic              shift,
	input  imas_pkg::sample_t d,
	output imas_pkg::sample_t q
);

	imas_pkg::sample_t smp_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			smp_q <= d;
		end
	end

	assign q = smp_q;

endmodule

// ===== design/imas_div_lane.sv =====
// ----------------------------------------------------------------------------
// IMU moving average divide lane
// Divides one running sum by the window length through an exact reciprocal
// multiply and selects the raw sample while the window is still filling.
// ----------------------------------------------------------------------------
module imas_div_lane #(
	parameter int WINDOW = imas_pkg::WINDOW_DEF,
	parameter int SUM_W  = imas_pkg::RAW_W + $clog2(imas_pkg::WINDOW_DEF)
) (
	input  logic                         clk,
	input  imas_pkg::lane_en_t           en,
	input  logic signed [SUM_W-1:0]      sum_s1,
	input  logic [imas_pkg::RAW_W-1:0]   raw_s1,
	input  logic                         full_s1,
	output logic [imas_pkg::RAW_W-1:0]   avg_s3
);

	localparam int L      = $clog2(WINDOW);
	localparam int K      = SUM_W + L;
	localparam int M_W    = SUM_W + 1;
	localparam int PROD_W = 2 * SUM_W + 1;
	localparam int Q_W    = imas_pkg::RAW_W + 1;
	localparam longint RECIP = ((longint'(1) << K) + WINDOW - 1) / WINDOW;
	localparam logic [M_W-1:0] RECIP_M = M_W'(RECIP);

	logic [SUM_W-1:0]           mag;
	logic [PROD_W-1:0]          prod_s2;
	logic                       neg_s2;
	logic                       full_s2;
	logic [imas_pkg::RAW_W-1:0] raw_s2;
	logic [Q_W-1:0]             quo;
	logic [Q_W-1:0]             quo_neg;
	logic [imas_pkg::RAW_W-1:0] val_s3;

	assign mag = sum_s1[SUM_W-1] ? SUM_W'(-sum_s1) : SUM_W'(sum_s1);

	always_ff @(posedge clk) begin
		if (en.s2) begin
			prod_s2 <= PROD_W'(mag) * PROD_W'(RECIP_M);
			neg_s2  <= sum_s1[SUM_W-1];
			full_s2 <= full_s1;
			raw_s2  <= raw_s1;
		end
	end

	assign quo     = prod_s2[K +: Q_W];
	assign quo_neg = -quo;

	always_ff @(posedge clk) begin
		if (en.s3) begin
			if (!full_s2) begin
				val_s3 <= raw_s2;
			end else if (neg_s2) begin
				val_s3 <= quo_neg[imas_pkg::RAW_W-1:0];
			end else begin
				val_s3 <= quo[imas_pkg::RAW_W-1:0];
			end
		end
	end

	assign avg_s3 = val_s3;

endmodule

// ===== design/imu_moving_average_scaler.sv =====
// ----------------------------------------------------------------------------
// IMU moving average scaler
// Averages accel and gyro over a sliding window, scales and trims gyro.
// ----------------------------------------------------------------------------
// One sample set is taken per clock cycle while in_stall is low. The first
// register updates the running sums as the chain of WINDOW cells shifts; the
// divide lanes register the reciprocal product, then the quotient; the next
// register scales and offsets the gyro; the output register applies the yaw
// deadband and saturation. Until WINDOW items have been taken the raw samples
// pass through; the item that fills the window is already averaged. The user
// must write gyro offsets and the yaw deadband through the configuration port
// only while no item is in flight; the block does not enforce this.
module imu_moving_average_scaler #(
	parameter int WINDOW = imas_pkg::WINDOW_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic signed [imas_pkg::RAW_W-1:0]     accel_x_raw,
	input  logic signed [imas_pkg::RAW_W-1:0]     accel_y_raw,
	input  logic signed [imas_pkg::RAW_W-1:0]     accel_z_raw,
	input  logic signed [imas_pkg::RAW_W-1:0]     gyro_x_raw,
	input  logic signed [imas_pkg::RAW_W-1:0]     gyro_y_raw,
	input  logic signed [imas_pkg::RAW_W-1:0]     gyro_z_raw,
	input  logic signed [imas_pkg::RAW_W-1:0]     mag_x_raw,
	input  logic signed [imas_pkg::RAW_W-1:0]     mag_y_raw,
	input  logic signed [imas_pkg::RAW_W-1:0]     mag_z_raw,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [imas_pkg::RAW_W-1:0]     accel_x_g,
	output logic signed [imas_pkg::RAW_W-1:0]     accel_y_g,
	output logic signed [imas_pkg::RAW_W-1:0]     accel_z_g,
	output logic signed [imas_pkg::GYRO_W-1:0]    gyro_x_dps,
	output logic signed [imas_pkg::GYRO_W-1:0]    gyro_y_dps,
	output logic signed [imas_pkg::GYRO_W-1:0]    gyro_z_dps,
	output logic signed [imas_pkg::RAW_W-1:0]     mag_x_out,
	output logic signed [imas_pkg::RAW_W-1:0]     mag_y_out,
	output logic signed [imas_pkg::RAW_W-1:0]     mag_z_out,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [imas_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [imas_pkg::OFS_W-1:0]            cfg_data
);

	localparam int SUM_W = imas_pkg::RAW_W + $clog2(WINDOW);
	localparam int CNT_W = $clog2(WINDOW);
	localparam int PG_W  = imas_pkg::RAW_W + 11;
	localparam int RAW_W = imas_pkg::RAW_W;
	localparam int GV_W  = imas_pkg::GV_W;

	imas_pkg::sample_t in_sample;
	imas_pkg::sample_t chain [WINDOW+1];
	imas_pkg::sample_t raw_s1;
	imas_pkg::tri_t    mag_s1, mag_s2, mag_s3, mag_s4, mag_q;
	imas_pkg::tri_t    acc_s4, acc_q;
	imas_pkg::lane_en_t lane_en;

	logic signed [SUM_W-1:0] sums_q   [imas_pkg::N_AXES];
	logic signed [SUM_W-1:0] sum_next [imas_pkg::N_AXES];
	logic signed [SUM_W-1:0] sum_s1   [imas_pkg::N_AXES];
	logic [RAW_W-1:0]        avg_s3   [imas_pkg::N_AXES];

	logic signed [PG_W-1:0]  gprod  [3];
	logic signed [GV_W-1:0]  gv     [3];
	logic signed [GV_W-1:0]  gv_s4  [3];
	logic signed [GV_W-1:0]  gsel   [3];
	logic [GV_W-1:0]         zmag;
	logic [imas_pkg::GYRO_W-1:0] gyro_q [3];

	logic signed [imas_pkg::OFS_W-1:0] gyro_offset_q [3];
	logic [imas_pkg::DB_W-1:0]         yaw_deadband_q;

	logic [CNT_W-1:0] cnt_q;
	logic             full_q;
	logic             full_after;
	logic             full_s1;
	logic             vld_s1, vld_s2, vld_s3, vld_s4, out_valid_q;
	logic             rdy1, rdy2, rdy3, rdy4, rdy_out;
	logic             accept;

	// Handshake: a stage takes new data when it is empty or drains this cycle.
	assign rdy_out  = !out_valid_q || !out_stall;
	assign rdy4     = !vld_s4 || rdy_out;
	assign rdy3     = !vld_s3 || rdy4;
	assign rdy2     = !vld_s2 || rdy3;
	assign rdy1     = !vld_s1 || rdy2;
	assign in_stall = !rdy1;
	assign accept   = in_valid && rdy1;
	assign lane_en  = '{s2: rdy2 && vld_s1, s3: rdy3 && vld_s2};

	assign in_sample = {gyro_z_raw, gyro_y_raw, gyro_x_raw,
		accel_z_raw, accel_y_raw, accel_x_raw};

	assign chain[0] = in_sample;

	for (genvar i = 0; i < WINDOW; i++) begin : g_cell
		imas_cell u_cell (
			.clk   (clk),
			.shift (accept),
			.d     (chain[i]),
			.q     (chain[i+1])
		);
	end

	assign full_after = full_q || (cnt_q == CNT_W'(WINDOW - 1));

	always_comb begin
		for (int a = 0; a < imas_pkg::N_AXES; a++) begin
			sum_next[a] = sums_q[a] + SUM_W'($signed(in_sample[a]));
			if (full_q) begin
				sum_next[a] = sum_next[a] - SUM_W'($signed(chain[WINDOW][a]));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			full_q <= 1'b0;
			for (int a = 0; a < imas_pkg::N_AXES; a++) begin
				sums_q[a] <= '0;
			end
		end else if (accept) begin
			for (int a = 0; a < imas_pkg::N_AXES; a++) begin
				sums_q[a] <= sum_next[a];
			end
			if (!full_q) begin
				if (cnt_q == CNT_W'(WINDOW - 1)) begin
					cnt_q  <= '0;
					full_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gyro_offset_q[0] <= '0;
			gyro_offset_q[1] <= '0;
			gyro_offset_q[2] <= '0;
			yaw_deadband_q   <= imas_pkg::YAW_DEADBAND_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				imas_pkg::CFG_GYRO_OFFSET_X: gyro_offset_q[0] <= cfg_data;
				imas_pkg::CFG_GYRO_OFFSET_Y: gyro_offset_q[1] <= cfg_data;
				imas_pkg::CFG_GYRO_OFFSET_Z: gyro_offset_q[2] <= cfg_data;
				imas_pkg::CFG_YAW_DEADBAND:  yaw_deadband_q <= cfg_data[imas_pkg::DB_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			vld_s3      <= 1'b0;
			vld_s4      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rdy1) begin
				vld_s1 <= in_valid;
			end
			if (rdy2) begin
				vld_s2 <= vld_s1;
			end
			if (rdy3) begin
				vld_s3 <= vld_s2;
			end
			if (rdy4) begin
				vld_s4 <= vld_s3;
			end
			if (rdy_out) begin
				out_valid_q <= vld_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			for (int a = 0; a < imas_pkg::N_AXES; a++) begin
				sum_s1[a] <= sum_next[a];
			end
			raw_s1  <= in_sample;
			full_s1 <= full_after;
			mag_s1  <= {mag_z_raw, mag_y_raw, mag_x_raw};
		end
		if (lane_en.s2) begin
			mag_s2 <= mag_s1;
		end
		if (lane_en.s3) begin
			mag_s3 <= mag_s2;
		end
	end

	for (genvar a = 0; a < imas_pkg::N_AXES; a++) begin : g_lane
		imas_div_lane #(
			.WINDOW (WINDOW),
			.SUM_W  (SUM_W)
		) u_lane (
			.clk     (clk),
			.en      (lane_en),
			.sum_s1  (sum_s1[a]),
			.raw_s1  (raw_s1[a]),
			.full_s1 (full_s1),
			.avg_s3  (avg_s3[a])
		);
	end

	// Gyro scaling by 1000/128 rounds toward minus infinity.
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			gprod[a] = PG_W'($signed(avg_s3[a+3])) * PG_W'(imas_pkg::GYRO_SCALE);
			gv[a]    = GV_W'($signed(gprod[a][PG_W-1:imas_pkg::GYRO_SHIFT]))
				- GV_W'(gyro_offset_q[a]);
		end
	end

	always_ff @(posedge clk) begin
		if (rdy4 && vld_s3) begin
			for (int a = 0; a < 3; a++) begin
				gv_s4[a]  <= gv[a];
				acc_s4[a] <= avg_s3[a];
			end
			mag_s4 <= mag_s3;
		end
	end

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			gsel[a] = gv_s4[a];
		end
		zmag = gv_s4[2][GV_W-1] ? GV_W'(-gv_s4[2]) : GV_W'(gv_s4[2]);
		if (zmag < GV_W'(yaw_deadband_q)) begin
			gsel[2] = '0;
		end
		for (int a = 0; a < 3; a++) begin
			if (gsel[a] > imas_pkg::GYRO_MAX) begin
				gsel[a] = imas_pkg::GYRO_MAX;
			end else if (gsel[a] < imas_pkg::GYRO_MIN) begin
				gsel[a] = imas_pkg::GYRO_MIN;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_out && vld_s4) begin
			for (int a = 0; a < 3; a++) begin
				gyro_q[a] <= gsel[a][imas_pkg::GYRO_W-1:0];
			end
			acc_q <= acc_s4;
			mag_q <= mag_s4;
		end
	end

	assign out_valid  = out_valid_q;
	assign accel_x_g  = acc_q[0];
	assign accel_y_g  = acc_q[1];
	assign accel_z_g  = acc_q[2];
	assign gyro_x_dps = gyro_q[0];
	assign gyro_y_dps = gyro_q[1];
	assign gyro_z_dps = gyro_q[2];
	assign mag_x_out  = mag_q[0];
	assign mag_y_out  = mag_q[1];
	assign mag_z_out  = mag_q[2];

endmodule

// ===== design/imas_checker.sv =====
// ----------------------------------------------------------------------------
// IMU moving average scaler checker
// Port-level checks on flow control and on the gyro output range.
// ----------------------------------------------------------------------------
`include "imu_moving_average_scaler_defines.svh"

module imas_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_stall,
	input logic                               out_valid,
	input logic                               out_stall,
	input logic [imas_pkg::RAW_W-1:0]         accel_x_g,
	input logic signed [imas_pkg::GYRO_W-1:0] gyro_x_dps,
	input logic signed [imas_pkg::GYRO_W-1:0] gyro_y_dps,
	input logic signed [imas_pkg::GYRO_W-1:0] gyro_z_dps
);

	// A stalled result item stays on the port.
	`IMAS_ASSERT(a_out_hold, clk, arst_n, out_valid && out_stall |=> out_valid, "result dropped while stalled")

	`IMAS_ASSERT(a_out_stable, clk, arst_n, out_valid && out_stall |=> $stable(accel_x_g), "stalled result changed")

	// With the output register empty nothing downstream can hold back an item.
	`IMAS_ASSERT_NEVER(a_no_idle_stall, clk, arst_n, !out_valid && in_stall, "input stalled with empty output")

	`IMAS_ASSERT(a_gyro_range, clk, arst_n, out_valid |-> (gyro_x_dps <= 20'sd327680) && (gyro_x_dps >= -20'sd327680) && (gyro_y_dps <= 20'sd327680) && (gyro_y_dps >= -20'sd327680) && (gyro_z_dps <= 20'sd327680) && (gyro_z_dps >= -20'sd327680), "gyro result out of range")

endmodule

bind imu_moving_average_scaler imas_checker u_imas_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.accel_x_g  (accel_x_g),
	.gyro_x_dps (gyro_x_dps),
	.gyro_y_dps (gyro_y_dps),
	.gyro_z_dps (gyro_z_dps)
);
